// ===== rtl/bbse_pkg.sv =====
// shared types and constants of the bitmap byte suppression encoder
package bbse_pkg;

    localparam int BYTE_W    = 8;
    localparam int TAIL_W    = 3;
    localparam int MAX_GROUP = 8;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_MAP,
        EMIT_DATA
    } emit_state_t;

    typedef struct packed {
        logic                  go;
        logic                  full;
        logic                  eos;
        logic [MAX_GROUP-1:0]  pend;
        logic [BYTE_W-1:0]     map;
        logic [TAIL_W-1:0]     tail;
    } launch_t;

endpackage

// ===== rtl/bbse_in_if.sv =====
// input channel of the encoder: one stream byte per transfer
interface bbse_in_if;
    logic                          valid;
    logic                          ready;
    logic [bbse_pkg::BYTE_W-1:0]   data_byte;
    logic                          end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/bbse_out_if.sv =====
// output channel of the encoder: one encoded byte per transfer
interface bbse_out_if;
    logic                          valid;
    logic                          ready;
    logic [bbse_pkg::BYTE_W-1:0]   out_byte;
    logic                          is_map;
    logic                          last_of_stream;
    logic [bbse_pkg::TAIL_W-1:0]   tail_count;

    modport source (output valid, output out_byte, output is_map, output last_of_stream,
                    output tail_count, input ready);
    modport sink   (input valid, input out_byte, input is_map, input last_of_stream,
                    input tail_count, output ready);
endinterface

// ===== rtl/bbse_group.sv =====
// group store, suppressed value compare and presence bits of the open group
module bbse_group #(
    parameter int GROUP_SIZE = 8
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         accept,
    input  logic [bbse_pkg::BYTE_W-1:0]                  data_byte,
    input  logic                                         end_of_stream,
    input  logic [bbse_pkg::BYTE_W-1:0]                  suppressed_value,
    input  logic [$clog2(GROUP_SIZE)-1:0]                rd_idx,
    output logic [bbse_pkg::BYTE_W-1:0]                  rd_data,
    output bbse_pkg::launch_t                            launch
);

    localparam int FILL_W = $clog2(GROUP_SIZE);

    logic [bbse_pkg::BYTE_W-1:0]    store_mem [GROUP_SIZE];
    logic [FILL_W-1:0]              fill_reg, fill_next;
    logic [GROUP_SIZE-1:0]          diff_reg, diff_next, diff_new;
    logic                           differs;
    logic                           full;

    assign differs = (data_byte != suppressed_value);
    assign full    = (fill_reg == FILL_W'(GROUP_SIZE - 1));

    always_comb
    begin
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            diff_new[i] = diff_reg[i] | (differs && (fill_reg == FILL_W'(i)));
        end

        launch      = '0;
        launch.go   = accept && (full || end_of_stream);
        launch.full = full;
        launch.eos  = end_of_stream;
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            launch.pend[i] = full ? diff_new[i] : (FILL_W'(i) <= fill_reg);
            launch.map[GROUP_SIZE-1-i] = diff_new[i];
        end
        launch.tail = full ? '0
                           : bbse_pkg::TAIL_W'(fill_reg) + bbse_pkg::TAIL_W'(1);

        fill_next = fill_reg;
        diff_next = diff_reg;
        if (launch.go)
        begin
            fill_next = '0;
            diff_next = '0;
        end
        else if (accept)
        begin
            fill_next = FILL_W'(fill_reg + 1'b1);
            diff_next = diff_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            diff_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            diff_reg <= diff_next;
        end
    end

    // registered read, the byte written in the same cycle is passed through
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_mem[fill_reg] <= data_byte;
        end
        if (accept && (fill_reg == rd_idx))
        begin
            rd_data <= data_byte;
        end
        else
        begin
            rd_data <= store_mem[rd_idx];
        end
    end

endmodule

// ===== rtl/bbse_emit.sv =====
// emit sequencer: walks the group and drives the registered output slot
module bbse_emit #(
    parameter int GROUP_SIZE = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bbse_pkg::launch_t                     launch,
    output logic                                  idle,
    output logic [$clog2(GROUP_SIZE)-1:0]         rd_idx,
    input  logic [bbse_pkg::BYTE_W-1:0]           rd_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bbse_pkg::BYTE_W-1:0]           out_byte,
    output logic                                  out_is_map,
    output logic                                  out_last,
    output logic [bbse_pkg::TAIL_W-1:0]           out_tail
);

    localparam int FILL_W = $clog2(GROUP_SIZE);

    bbse_pkg::emit_state_t           state_reg, state_next;
    logic [GROUP_SIZE-1:0]           pend_reg, pend_next, rest;
    logic [bbse_pkg::BYTE_W-1:0]     map_reg, map_next;
    logic                            eos_reg, eos_next;
    logic [bbse_pkg::TAIL_W-1:0]     tail_reg, tail_next;
    logic [FILL_W-1:0]               idx_reg, idx_next;

    logic                            ovalid_reg, ovalid_next;
    logic [bbse_pkg::BYTE_W-1:0]     obyte_reg, obyte_next;
    logic                            omap_reg, omap_next;
    logic                            olast_reg, olast_next;
    logic [bbse_pkg::TAIL_W-1:0]     otail_reg, otail_next;

    logic                            slot_free;
    logic                            load;

    assign slot_free  = !ovalid_reg || out_ready;
    assign idle       = (state_reg == bbse_pkg::EMIT_IDLE);
    // store read is registered, so address it with the next position
    assign rd_idx     = idx_next;
    assign rest       = pend_reg & ~(GROUP_SIZE'(1) << idx_reg);
    assign out_valid  = ovalid_reg;
    assign out_byte   = obyte_reg;
    assign out_is_map = omap_reg;
    assign out_last   = olast_reg;
    assign out_tail   = otail_reg;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        map_next   = map_reg;
        eos_next   = eos_reg;
        tail_next  = tail_reg;
        idx_next   = idx_reg;
        load       = 1'b0;
        obyte_next = obyte_reg;
        omap_next  = omap_reg;
        olast_next = olast_reg;
        otail_next = otail_reg;

        case (state_reg)
            bbse_pkg::EMIT_IDLE:
            begin
                if (launch.go)
                begin
                    pend_next  = launch.pend[GROUP_SIZE-1:0];
                    map_next   = launch.map;
                    eos_next   = launch.eos;
                    tail_next  = launch.tail;
                    idx_next   = '0;
                    state_next = launch.full ? bbse_pkg::EMIT_MAP : bbse_pkg::EMIT_DATA;
                end
            end
            bbse_pkg::EMIT_MAP:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    obyte_next = map_reg;
                    omap_next  = 1'b1;
                    olast_next = eos_reg && (pend_reg == '0);
                    otail_next = '0;
                    state_next = (pend_reg == '0) ? bbse_pkg::EMIT_IDLE
                                                  : bbse_pkg::EMIT_DATA;
                end
            end
            bbse_pkg::EMIT_DATA:
            begin
                if (!pend_reg[idx_reg])
                begin
                    idx_next = FILL_W'(idx_reg + 1'b1);
                end
                else if (slot_free)
                begin
                    load       = 1'b1;
                    obyte_next = rd_data;
                    omap_next  = 1'b0;
                    olast_next = eos_reg && (rest == '0);
                    otail_next = (eos_reg && (rest == '0)) ? tail_reg : '0;
                    pend_next  = rest;
                    idx_next   = FILL_W'(idx_reg + 1'b1);
                    if (rest == '0)
                    begin
                        state_next = bbse_pkg::EMIT_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bbse_pkg::EMIT_IDLE;
            end
        endcase

        ovalid_next = load ? 1'b1 : (out_ready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bbse_pkg::EMIT_IDLE;
            ovalid_reg <= 1'b0;
            pend_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        map_reg   <= map_next;
        eos_reg   <= eos_next;
        tail_reg  <= tail_next;
        idx_reg   <= idx_next;
        obyte_reg <= obyte_next;
        omap_reg  <= omap_next;
        olast_reg <= olast_next;
        otail_reg <= otail_next;
    end

endmodule

// ===== rtl/bitmap_byte_suppression_encoder.sv =====
// top level of the bitmap byte suppression encoder
// A byte that does not close a group or the stream is taken and the block is ready again
// the next cycle. A byte that closes a full group or ends the stream is taken and is
// followed by an emit pass, during which no transfer is taken: the map first on a full
// group, then each store position in turn up to the last one still to send, held up by
// output back pressure. The pass is paced by the single byte-wide output register, loaded
// once per cycle while the output slot is free by the sequencer as it walks the group
// store. No clearing pass after reset.
module bitmap_byte_suppression_encoder #(
    parameter int GROUP_SIZE = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bbse_in_if.sink                        in_ch,
    bbse_out_if.source                     out_ch,
    input  logic                           cfg_wr_en,
    input  logic [bbse_pkg::BYTE_W-1:0]    cfg_wr_data
);

    localparam int FILL_W = $clog2(GROUP_SIZE);

    logic [bbse_pkg::BYTE_W-1:0]    supp_reg, supp_next;
    logic                           idle;
    logic                           accept;
    logic [FILL_W-1:0]              rd_idx;
    logic [bbse_pkg::BYTE_W-1:0]    rd_data;
    bbse_pkg::launch_t              launch;

    assign in_ch.ready = idle;
    assign accept      = in_ch.valid && idle;
    assign supp_next   = cfg_wr_en ? cfg_wr_data : supp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supp_reg <= '0;
        end
        else
        begin
            supp_reg <= supp_next;
        end
    end

    bbse_group #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_group (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .data_byte        (in_ch.data_byte),
        .end_of_stream    (in_ch.end_of_stream),
        .suppressed_value (supp_reg),
        .rd_idx           (rd_idx),
        .rd_data          (rd_data),
        .launch           (launch)
    );

    bbse_emit #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .launch     (launch),
        .idle       (idle),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_byte   (out_ch.out_byte),
        .out_is_map (out_ch.is_map),
        .out_last   (out_ch.last_of_stream),
        .out_tail   (out_ch.tail_count)
    );

`ifndef NO_ASSERTIONS
    // end of stream always starts an emit pass
    a_eos_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.end_of_stream |=> !in_ch.ready)
        else $error("end of stream transfer did not start an emit pass");

    // a map never carries a tail length
    a_map_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.is_map |-> out_ch.tail_count == '0)
        else $error("map byte with nonzero tail count");

    // tail length only on the final transfer of a stream
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.tail_count != '0) |-> out_ch.last_of_stream)
        else $error("tail count without last of stream");
`endif

endmodule

// ===== tb/encoder_scoreboard.sv =====
// checker that predicts the encoded byte stream and compares it with the block's output
module encoder_scoreboard #(
    parameter int GROUP_SIZE = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bbse_in_if                          in_ch,
    bbse_out_if                         out_ch,
    input  logic                        cfg_wr_en,
    input  logic [bbse_pkg::BYTE_W-1:0] cfg_wr_data,
    output int                          fail_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bbse_pkg::BYTE_W-1:0] out_byte;
        logic                        is_map;
        logic                        last_of_stream;
        logic [bbse_pkg::TAIL_W-1:0] tail_count;
    } enc_out_t;

    enc_out_t                    encoded_q[$];
    logic [bbse_pkg::BYTE_W-1:0] suppressed;
    logic [bbse_pkg::BYTE_W-1:0] group_bytes[bbse_pkg::MAX_GROUP];
    logic [bbse_pkg::BYTE_W-1:0] group_map;
    int                          group_fill;

    task automatic encode_byte(input logic [bbse_pkg::BYTE_W-1:0] b, input logic eos);
        enc_out_t res[bbse_pkg::MAX_GROUP+1];
        int       n;
        n = 0;
        group_bytes[group_fill] = b;
        if (b != suppressed)
            group_map[GROUP_SIZE-1-group_fill] = 1'b1;
        group_fill++;
        if (group_fill == GROUP_SIZE)
        begin
            res[n++] = '{out_byte: group_map, is_map: 1'b1, last_of_stream: 1'b0,
                         tail_count: '0};
            for (int i = 0; i < GROUP_SIZE; i++)
                if (group_map[GROUP_SIZE-1-i])
                    res[n++] = '{out_byte: group_bytes[i], is_map: 1'b0,
                                 last_of_stream: 1'b0, tail_count: '0};
            if (eos)
                res[n-1].last_of_stream = 1'b1;
        end
        else if (eos)
        begin
            // partial tail goes out raw, suppressed bytes included
            for (int i = 0; i < group_fill; i++)
                res[n++] = '{out_byte: group_bytes[i], is_map: 1'b0,
                             last_of_stream: 1'b0, tail_count: '0};
            res[n-1].last_of_stream = 1'b1;
            res[n-1].tail_count = bbse_pkg::TAIL_W'(group_fill);
        end
        for (int i = 0; i < n; i++)
            encoded_q.push_back(res[i]);
        if (group_fill == GROUP_SIZE || eos)
        begin
            group_fill = 0;
            group_map = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_out_t exp_res;
        if (!rst_n)
        begin
            encoded_q.delete();
            suppressed = '0;
            group_map = '0;
            group_fill = 0;
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (encoded_q.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %0h is_map %0b", out_ch.out_byte,
                           out_ch.is_map);
                    fail_count++;
                end
                else
                begin
                    exp_res = encoded_q.pop_front();
                    if (out_ch.out_byte !== exp_res.out_byte)
                    begin
                        $error("out_byte: expected %0h, actual %0h", exp_res.out_byte,
                               out_ch.out_byte);
                        fail_count++;
                    end
                    if (out_ch.is_map !== exp_res.is_map)
                    begin
                        $error("is_map: expected %0b, actual %0b", exp_res.is_map,
                               out_ch.is_map);
                        fail_count++;
                    end
                    if (out_ch.last_of_stream !== exp_res.last_of_stream)
                    begin
                        $error("last_of_stream: expected %0b, actual %0b",
                               exp_res.last_of_stream, out_ch.last_of_stream);
                        fail_count++;
                    end
                    if (out_ch.tail_count !== exp_res.tail_count)
                    begin
                        $error("tail_count: expected %0d, actual %0d", exp_res.tail_count,
                               out_ch.tail_count);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                encode_byte(in_ch.data_byte, in_ch.end_of_stream);
            if (cfg_wr_en)
                suppressed = cfg_wr_data;
            outstanding = encoded_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the bitmap byte suppression encoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUP_SIZE = 8;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [bbse_pkg::BYTE_W-1:0] cfg_wr_data;
    int                          fail_count;
    int                          outstanding;
    bit                          send_idle;
    bit                          recv_idle;
    bit                          hold_req;
    logic [bbse_pkg::BYTE_W-1:0] supp;

    bbse_in_if  in_ch();
    bbse_out_if out_ch();

    bitmap_byte_suppression_encoder #(.GROUP_SIZE(GROUP_SIZE)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    encoder_scoreboard #(.GROUP_SIZE(GROUP_SIZE)) scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("bitmap_byte_suppression_encoder: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [bbse_pkg::BYTE_W-1:0] b, input logic eos);
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_stream <= eos;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic write_suppressed(input logic [bbse_pkg::BYTE_W-1:0] v);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (16) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        supp = v;
    endtask

    task automatic send_stream(input int len);
        bit keep_idle;
        keep_idle = send_idle;
        // some streams run without sender gaps
        if ($urandom_range(0, 3) == 0)
            send_idle = 1'b0;
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(0, 1) ? supp : 8'($urandom_range(0, 255)), i == len - 1);
        send_idle = keep_idle;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [bbse_pkg::BYTE_W-1:0] mixed_group[8];
        logic [bbse_pkg::BYTE_W-1:0] short_tail[7];
        logic [bbse_pkg::BYTE_W-1:0] phase_vals[4];
        int                          sent;
        int                          len;
        mixed_group = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h00, 8'h7F, 8'hFF};
        short_tail = '{8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h01};
        phase_vals = '{8'hFF, 8'($urandom_range(1, 254)), 8'h80, 8'($urandom_range(0, 255))};
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.end_of_stream <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        hold_req = 1'b0;
        supp = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_suppressed(8'h00);
        // full group ending the stream, last on the final literal
        for (int i = 0; i < 8; i++)
            send_byte(mixed_group[i], i == 7);
        // all-suppressed group: map alone carries the end
        for (int i = 0; i < 8; i++)
            send_byte(8'h00, i == 7);
        // one-byte tail that is the suppressed value
        send_byte(8'h00, 1'b1);
        // longest partial tail
        for (int i = 0; i < 7; i++)
            send_byte(short_tail[i], i == 6);

        for (int ph = 0; ph < 4; ph++)
        begin
            write_suppressed(phase_vals[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 3)
            begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            sent = 0;
            while (sent < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16);
                send_stream(len);
                sent += len;
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("bitmap_byte_suppression_encoder: match");
        else
            $display("bitmap_byte_suppression_encoder: mismatch");
        $finish;
    end

endmodule
